@@ src/jspg_pkg.sv @@
// Shared constants, codes and types of the joystick step/direction generator.
`timescale 1ns / 1ps
`default_nettype none

package jspg_pkg;

    // Field widths
    localparam int SAMPLE_BITS   = 12;
    localparam int PERIOD_BITS   = 16;
    localparam int POSITION_BITS = 32;

    localparam int DEAD_BITS     = SAMPLE_BITS - 1;
    localparam int PROD_BITS     = SAMPLE_BITS + PERIOD_BITS;
    localparam int DIV_CNT_BITS  = $clog2(PERIOD_BITS + 1);
    localparam int CFG_DATA_BITS = (PERIOD_BITS > SAMPLE_BITS) ? PERIOD_BITS : SAMPLE_BITS;
    localparam int CFG_IDX_BITS  = 2;

    // Command queue between front and back
    localparam int QUEUE_DEPTH   = 2;
    localparam int QPTR_BITS     = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_BITS     = $clog2(QUEUE_DEPTH + 1);

    // Largest joystick reading
    localparam logic [SAMPLE_BITS-1:0] FULL_SCALE = {SAMPLE_BITS{1'b1}};

    // Register reset values
    localparam logic [SAMPLE_BITS-1:0] CENTER_RESET = SAMPLE_BITS'(1) << (SAMPLE_BITS - 1);
    localparam logic [DEAD_BITS-1:0]   DEAD_RESET   = DEAD_BITS'(100);
    localparam logic [PERIOD_BITS-1:0] MAX_RESET    = PERIOD_BITS'(1000);
    localparam logic [PERIOD_BITS-1:0] MIN_RESET    = PERIOD_BITS'(100);

    // Register indexes
    localparam logic [CFG_IDX_BITS-1:0] CFG_CENTER      = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_DEADBAND    = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SLOW_PERIOD = 2'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_FAST_PERIOD = 2'd3;

    // Operation codes
    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_TICK   = 1'b1;

    // Per-axis action decided by the front
    typedef enum logic [1:0] {
        ACT_HALT = 2'd0,
        ACT_UP   = 2'd1,
        ACT_DOWN = 2'd2
    } act_e_t;

    typedef struct packed {
        act_e_t                 act;
        logic [PROD_BITS-1:0]   num;
        logic [SAMPLE_BITS-1:0] den;
    } axis_cmd_t;

    typedef struct packed {
        logic                 op;
        axis_cmd_t [1:0]      axis;
    } cmd_t;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] center;
        logic [DEAD_BITS-1:0]   deadband;
        logic [PERIOD_BITS-1:0] slow_period;
        logic [PERIOD_BITS-1:0] fast_period;
    } cfg_t;

    // Queue handshake between front, queue and back
    typedef struct packed {
        logic full;
        logic empty;
    } qstat_t;

endpackage

`default_nettype wire

@@ src/jspg_ifs.sv @@
// Channel interfaces: joystick/tick requests, results and configuration writes.
`timescale 1ns / 1ps
`default_nettype none

interface jspg_req_if;
    logic                               valid;
    logic                               ready;
    logic                               operation;
    logic [jspg_pkg::SAMPLE_BITS-1:0]   joy_axis1;
    logic [jspg_pkg::SAMPLE_BITS-1:0]   joy_axis2;
    logic                               limit_up_axis1;
    logic                               limit_down_axis1;
    logic                               limit_up_axis2;
    logic                               limit_down_axis2;

    modport source (
        output valid, operation, joy_axis1, joy_axis2,
               limit_up_axis1, limit_down_axis1, limit_up_axis2, limit_down_axis2,
        input  ready
    );
    modport sink (
        input  valid, operation, joy_axis1, joy_axis2,
               limit_up_axis1, limit_down_axis1, limit_up_axis2, limit_down_axis2,
        output ready
    );
endinterface

interface jspg_rsp_if;
    logic                                      valid;
    logic                                      ready;
    logic                                      step_axis1;
    logic                                      dir_axis1;
    logic                                      run_axis1;
    logic signed [jspg_pkg::POSITION_BITS-1:0] position_axis1;
    logic                                      step_axis2;
    logic                                      dir_axis2;
    logic                                      run_axis2;
    logic signed [jspg_pkg::POSITION_BITS-1:0] position_axis2;
    logic [jspg_pkg::PERIOD_BITS-1:0]          period_axis1;
    logic [jspg_pkg::PERIOD_BITS-1:0]          period_axis2;

    modport source (
        output valid, step_axis1, dir_axis1, run_axis1, position_axis1,
               step_axis2, dir_axis2, run_axis2, position_axis2,
               period_axis1, period_axis2,
        input  ready
    );
    modport sink (
        input  valid, step_axis1, dir_axis1, run_axis1, position_axis1,
               step_axis2, dir_axis2, run_axis2, position_axis2,
               period_axis1, period_axis2,
        output ready
    );
endinterface

interface jspg_cfg_if;
    logic                                 valid;
    logic                                 ready;
    logic [jspg_pkg::CFG_IDX_BITS-1:0]    index;
    logic [jspg_pkg::CFG_DATA_BITS-1:0]   data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

@@ src/jspg_front.sv @@
// Front end: accepts request beats, classifies each axis and forms the divide operands.
`timescale 1ns / 1ps
`default_nettype none

module jspg_front (
    jspg_req_if.sink            req,
    input  jspg_pkg::cfg_t      cfg,
    input  jspg_pkg::qstat_t    qstat,
    output logic                push,
    output jspg_pkg::cmd_t      cmd
);

    logic [jspg_pkg::SAMPLE_BITS:0]   hi;
    logic                             lo_pos;
    logic [jspg_pkg::SAMPLE_BITS-1:0] lo;
    logic [jspg_pkg::PERIOD_BITS-1:0] span;
    logic [jspg_pkg::SAMPLE_BITS-1:0] joy   [2];
    logic                             lim_up [2];
    logic                             lim_dn [2];
    logic [jspg_pkg::SAMPLE_BITS-1:0] diff  [2];

    // Take a beat whenever the queue has room
    assign req.ready = ~qstat.full;
    assign push      = req.valid & ~qstat.full;

    assign joy[0]    = req.joy_axis1;
    assign joy[1]    = req.joy_axis2;
    assign lim_up[0] = req.limit_up_axis1;
    assign lim_up[1] = req.limit_up_axis2;
    assign lim_dn[0] = req.limit_down_axis1;
    assign lim_dn[1] = req.limit_down_axis2;

    // Band edges and period span from the registers
    always_comb
    begin
        hi     = {1'b0, cfg.center} + {2'b00, cfg.deadband};
        lo_pos = cfg.center > {1'b0, cfg.deadband};
        lo     = cfg.center - {1'b0, cfg.deadband};
        span   = (cfg.slow_period >= cfg.fast_period) ?
                 (cfg.slow_period - cfg.fast_period) : '0;
    end

    // Classify each axis and build numerator and divisor
    always_comb
    begin
        cmd.op = req.operation;
        for (int a = 0; a < 2; a++)
        begin
            if ({1'b0, joy[a]} > hi)
            begin
                cmd.axis[a].act = lim_up[a] ? jspg_pkg::ACT_HALT : jspg_pkg::ACT_UP;
                diff[a]         = joy[a] - hi[jspg_pkg::SAMPLE_BITS-1:0];
                cmd.axis[a].den = jspg_pkg::FULL_SCALE - hi[jspg_pkg::SAMPLE_BITS-1:0];
            end
            else if (lo_pos && (joy[a] < lo))
            begin
                cmd.axis[a].act = lim_dn[a] ? jspg_pkg::ACT_HALT : jspg_pkg::ACT_DOWN;
                diff[a]         = lo - joy[a];
                cmd.axis[a].den = lo;
            end
            else
            begin
                cmd.axis[a].act = jspg_pkg::ACT_HALT;
                diff[a]         = '0;
                cmd.axis[a].den = '0;
            end
            cmd.axis[a].num = jspg_pkg::PROD_BITS'(diff[a]) * jspg_pkg::PROD_BITS'(span);
        end
    end

endmodule

`default_nettype wire

@@ src/jspg_queue.sv @@
// Short command queue that decouples the front end from the back end.
`timescale 1ns / 1ps
`default_nettype none

module jspg_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  jspg_pkg::cmd_t      wr_data,
    input  logic                pop,
    output jspg_pkg::cmd_t      rd_data,
    output jspg_pkg::qstat_t    qstat
);

    jspg_pkg::cmd_t                  entry_reg [jspg_pkg::QUEUE_DEPTH];
    logic [jspg_pkg::QPTR_BITS-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [jspg_pkg::QPTR_BITS-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [jspg_pkg::QCNT_BITS-1:0]  count_reg, count_next;
    logic                            do_push;
    logic                            do_pop;

    assign qstat.full  = (count_reg == jspg_pkg::QCNT_BITS'(jspg_pkg::QUEUE_DEPTH));
    assign qstat.empty = (count_reg == '0);
    assign do_push     = push & ~qstat.full;
    assign do_pop      = pop & ~qstat.empty;
    assign rd_data     = entry_reg[rd_ptr_reg];

    // Advance pointers with wrap at the queue depth
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == jspg_pkg::QPTR_BITS'(jspg_pkg::QUEUE_DEPTH - 1)) ?
                          '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == jspg_pkg::QPTR_BITS'(jspg_pkg::QUEUE_DEPTH - 1)) ?
                          '0 : rd_ptr_reg + 1'b1;
        end
        case ({do_push, do_pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the pushed command
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

`default_nettype wire

@@ src/jspg_divider.sv @@
// Restoring divider, one quotient bit per cycle, for the period scaling.
`timescale 1ns / 1ps
`default_nettype none

module jspg_divider (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic [jspg_pkg::PROD_BITS-1:0]      num,
    input  logic [jspg_pkg::SAMPLE_BITS-1:0]    den,
    output logic                                busy,
    output logic [jspg_pkg::PERIOD_BITS-1:0]    quo
);

    logic [jspg_pkg::SAMPLE_BITS-1:0]   rem_reg, rem_next;
    logic [jspg_pkg::PERIOD_BITS-1:0]   quo_reg, quo_next;
    logic [jspg_pkg::SAMPLE_BITS-1:0]   den_reg, den_next;
    logic [jspg_pkg::DIV_CNT_BITS-1:0]  cnt_reg, cnt_next;
    logic                               busy_reg, busy_next;
    logic [jspg_pkg::SAMPLE_BITS:0]     trial;
    logic [jspg_pkg::SAMPLE_BITS:0]     diff;
    logic                               ge;

    assign busy = busy_reg;
    assign quo  = quo_reg;

    // One shift-subtract step; the quotient fits the period width
    always_comb
    begin
        trial     = {rem_reg, quo_reg[jspg_pkg::PERIOD_BITS-1]};
        diff      = trial - {1'b0, den_reg};
        ge        = (trial >= {1'b0, den_reg});
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (start)
        begin
            rem_next  = num[jspg_pkg::PROD_BITS-1:jspg_pkg::PERIOD_BITS];
            quo_next  = num[jspg_pkg::PERIOD_BITS-1:0];
            den_next  = den;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? diff[jspg_pkg::SAMPLE_BITS-1:0] : trial[jspg_pkg::SAMPLE_BITS-1:0];
            quo_next = {quo_reg[jspg_pkg::PERIOD_BITS-2:0], ge};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == jspg_pkg::DIV_CNT_BITS'(jspg_pkg::PERIOD_BITS - 1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
    end

endmodule

`default_nettype wire

@@ src/jspg_back.sv @@
// Back end: runs tick and sample commands on the axis state and holds the result beat.
`timescale 1ns / 1ps
`default_nettype none

module jspg_back (
    input  logic                clk,
    input  logic                rst_n,
    input  jspg_pkg::cfg_t      cfg,
    input  jspg_pkg::qstat_t    qstat,
    input  jspg_pkg::cmd_t      head,
    output logic                pop,
    jspg_rsp_if.source          rsp
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_DIV  = 3'b010,
        ST_PUB  = 3'b100
    } state_t;

    state_t                                 state_reg, state_next;
    jspg_pkg::cmd_t                         cur_reg, cur_next;

    logic [jspg_pkg::PERIOD_BITS-1:0]       tick_reg   [2];
    logic [jspg_pkg::PERIOD_BITS-1:0]       tick_next  [2];
    logic [jspg_pkg::PERIOD_BITS-1:0]       reload_reg [2];
    logic [jspg_pkg::PERIOD_BITS-1:0]       reload_next[2];
    logic                                   step_reg   [2];
    logic                                   step_next  [2];
    logic                                   dir_reg    [2];
    logic                                   dir_next   [2];
    logic                                   run_reg    [2];
    logic                                   run_next   [2];
    logic [jspg_pkg::POSITION_BITS-1:0]     pos_reg    [2];
    logic [jspg_pkg::POSITION_BITS-1:0]     pos_next   [2];

    logic                                   out_valid_reg, out_valid_next;
    logic                                   load_out;
    logic                                   o_step_reg [2];
    logic                                   o_dir_reg  [2];
    logic                                   o_run_reg  [2];
    logic [jspg_pkg::POSITION_BITS-1:0]     o_pos_reg  [2];
    logic [jspg_pkg::PERIOD_BITS-1:0]       o_per_reg  [2];

    logic                                   div_start;
    logic                                   div_busy [2];
    logic [jspg_pkg::PERIOD_BITS-1:0]       div_quo  [2];

    // One divider per axis, both started together
    for (genvar g = 0; g < 2; g++)
    begin : g_div
        jspg_divider u_div (
            .clk   (clk),
            .rst_n (rst_n),
            .start (div_start),
            .num   (head.axis[g].num),
            .den   (head.axis[g].den),
            .busy  (div_busy[g]),
            .quo   (div_quo[g])
        );
    end

    // Sequence commands and update axis state
    always_comb
    begin
        state_next     = state_reg;
        cur_next       = cur_reg;
        pop            = 1'b0;
        div_start      = 1'b0;
        load_out       = 1'b0;
        out_valid_next = out_valid_reg & ~rsp.ready;
        for (int a = 0; a < 2; a++)
        begin
            tick_next[a]   = tick_reg[a];
            reload_next[a] = reload_reg[a];
            step_next[a]   = step_reg[a];
            dir_next[a]    = dir_reg[a];
            run_next[a]    = run_reg[a];
            pos_next[a]    = pos_reg[a];
        end
        case (state_reg)
            ST_IDLE:
            begin
                if (!qstat.empty)
                begin
                    pop      = 1'b1;
                    cur_next = head;
                    if (head.op == jspg_pkg::OP_TICK)
                    begin
                        // Advance running axes, toggle step when count reaches the period
                        for (int a = 0; a < 2; a++)
                        begin
                            if (run_reg[a])
                            begin
                                if (tick_reg[a] >= reload_reg[a])
                                begin
                                    tick_next[a] = '0;
                                    step_next[a] = ~step_reg[a];
                                    if (!step_reg[a])
                                    begin
                                        pos_next[a] = dir_reg[a] ?
                                            pos_reg[a] + jspg_pkg::POSITION_BITS'(1) :
                                            pos_reg[a] - jspg_pkg::POSITION_BITS'(1);
                                    end
                                end
                                else
                                begin
                                    tick_next[a] = tick_reg[a] + 1'b1;
                                end
                            end
                        end
                        state_next = ST_PUB;
                    end
                    else
                    begin
                        div_start  = 1'b1;
                        state_next = ST_DIV;
                    end
                end
            end
            ST_DIV:
            begin
                if (!div_busy[0] && !div_busy[1])
                begin
                    // Apply the sample: halt, or run with the scaled period
                    for (int a = 0; a < 2; a++)
                    begin
                        case (cur_reg.axis[a].act)
                            jspg_pkg::ACT_HALT:
                            begin
                                run_next[a]  = 1'b0;
                                step_next[a] = 1'b0;
                            end
                            jspg_pkg::ACT_UP,
                            jspg_pkg::ACT_DOWN:
                            begin
                                dir_next[a]    = (cur_reg.axis[a].act == jspg_pkg::ACT_UP);
                                run_next[a]    = 1'b1;
                                reload_next[a] = cfg.slow_period - div_quo[a];
                                tick_next[a]   = '0;
                            end
                            default:
                            begin
                                run_next[a] = run_reg[a];
                            end
                        endcase
                    end
                    state_next = ST_PUB;
                end
            end
            ST_PUB:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    load_out       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            for (int a = 0; a < 2; a++)
            begin
                tick_reg[a]   <= '0;
                reload_reg[a] <= '0;
                step_reg[a]   <= 1'b0;
                dir_reg[a]    <= 1'b0;
                run_reg[a]    <= 1'b0;
                pos_reg[a]    <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            for (int a = 0; a < 2; a++)
            begin
                tick_reg[a]   <= tick_next[a];
                reload_reg[a] <= reload_next[a];
                step_reg[a]   <= step_next[a];
                dir_reg[a]    <= dir_next[a];
                run_reg[a]    <= run_next[a];
                pos_reg[a]    <= pos_next[a];
            end
        end
    end

    // Hold the current command and the result beat
    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
        if (load_out)
        begin
            for (int a = 0; a < 2; a++)
            begin
                o_step_reg[a] <= step_reg[a];
                o_dir_reg[a]  <= dir_reg[a];
                o_run_reg[a]  <= run_reg[a];
                o_pos_reg[a]  <= pos_reg[a];
                o_per_reg[a]  <= reload_reg[a];
            end
        end
    end

    assign rsp.valid          = out_valid_reg;
    assign rsp.step_axis1     = o_step_reg[0];
    assign rsp.dir_axis1      = o_dir_reg[0];
    assign rsp.run_axis1      = o_run_reg[0];
    assign rsp.position_axis1 = o_pos_reg[0];
    assign rsp.step_axis2     = o_step_reg[1];
    assign rsp.dir_axis2      = o_dir_reg[1];
    assign rsp.run_axis2      = o_run_reg[1];
    assign rsp.position_axis2 = o_pos_reg[1];
    assign rsp.period_axis1   = o_per_reg[0];
    assign rsp.period_axis2   = o_per_reg[1];

`ifndef SYNTHESIS
    // A stopped axis always has its step low
    a_step_run0: assert property (@(posedge clk) disable iff (!rst_n)
        step_reg[0] |-> run_reg[0]) else $error("axis 1 step high while stopped");
    a_step_run1: assert property (@(posedge clk) disable iff (!rst_n)
        step_reg[1] |-> run_reg[1]) else $error("axis 2 step high while stopped");
    // The tick counter never runs past the reload period
    a_tick_le0: assert property (@(posedge clk) disable iff (!rst_n)
        tick_reg[0] <= reload_reg[0]) else $error("axis 1 counter past period");
    a_tick_le1: assert property (@(posedge clk) disable iff (!rst_n)
        tick_reg[1] <= reload_reg[1]) else $error("axis 2 counter past period");
    // Both dividers run in lockstep
    a_div_sync: assert property (@(posedge clk) disable iff (!rst_n)
        div_busy[0] == div_busy[1]) else $error("dividers out of step");
`endif

endmodule

`default_nettype wire

@@ src/joystick_stepper_pulse_generator_top.sv @@
// A tick beat goes from the command queue through the back end's idle and publish states
// into the result register on rsp; a sample beat also waits in the divide state for the
// sixteen-step divide of the reload period (one bit per cycle). The publish state waits
// while rsp holds a result; a two-entry command queue lets req take beats in the meantime.
// Reset (rst_n low, asynchronous): axes stopped, all counters, periods and positions zero,
// registers at their default values; no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module joystick_stepper_pulse_generator_top (
    input  wire logic   clk,
    input  wire logic   rst_n,
    jspg_req_if.sink    req,
    jspg_rsp_if.source  rsp,
    jspg_cfg_if.sink    cfg
);

    jspg_pkg::cfg_t     cfg_reg, cfg_next;
    jspg_pkg::cmd_t     push_cmd;
    jspg_pkg::cmd_t     head_cmd;
    jspg_pkg::qstat_t   qstat;
    logic               push;
    logic               pop;

    assign cfg.ready = 1'b1;

    // Decode register writes
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg.valid)
        begin
            case (cfg.index)
                jspg_pkg::CFG_CENTER:
                    cfg_next.center      = cfg.data[jspg_pkg::SAMPLE_BITS-1:0];
                jspg_pkg::CFG_DEADBAND:
                    cfg_next.deadband    = cfg.data[jspg_pkg::DEAD_BITS-1:0];
                jspg_pkg::CFG_SLOW_PERIOD:
                    cfg_next.slow_period = cfg.data[jspg_pkg::PERIOD_BITS-1:0];
                jspg_pkg::CFG_FAST_PERIOD:
                    cfg_next.fast_period = cfg.data[jspg_pkg::PERIOD_BITS-1:0];
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.center      <= jspg_pkg::CENTER_RESET;
            cfg_reg.deadband    <= jspg_pkg::DEAD_RESET;
            cfg_reg.slow_period <= jspg_pkg::MAX_RESET;
            cfg_reg.fast_period <= jspg_pkg::MIN_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    jspg_front u_front (
        .req   (req),
        .cfg   (cfg_reg),
        .qstat (qstat),
        .push  (push),
        .cmd   (push_cmd)
    );

    jspg_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .wr_data (push_cmd),
        .pop     (pop),
        .rd_data (head_cmd),
        .qstat   (qstat)
    );

    jspg_back u_back (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_reg),
        .qstat (qstat),
        .head  (head_cmd),
        .pop   (pop),
        .rsp   (rsp)
    );

endmodule

`default_nettype wire
